[hw/rtl/efl_pkg.sv]
// shared types and constants for the erase-on-full entry log
package efl_pkg;

    localparam int SLOTS   = 128;
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int PTR_W   = $clog2(SLOTS + 1);
    localparam int HALF_W  = 64;
    localparam int ENTRY_W = 2 * HALF_W;
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 8;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(SLOTS - 1);
    localparam logic [PTR_W-1:0]  FULL_PTR  = PTR_W'(SLOTS);

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_READ    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_RECOVER = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [HALF_W-1:0]  entry_low;
        logic [HALF_W-1:0]  entry_high;
        logic [INDEX_W-1:0] read_index;
    } cmd_t;

    typedef struct packed {
        logic [HALF_W-1:0]  data_low;
        logic [HALF_W-1:0]  data_high;
        logic               read_valid;
        logic [COUNT_W-1:0] entry_count;
    } res_t;

    typedef struct packed {
        logic              clr_all;
        logic              set_en;
        logic [ADDR_W-1:0] set_addr;
        logic [ADDR_W-1:0] rd_addr;
    } vctl_t;

endpackage

[hw/rtl/erase_on_full_entry_log.sv]
// top level of the erase-on-full entry log
// result: append and clear in the cycle after acceptance, read at the end of ST_READ
// recover: scans the slots from slot 0 up, one slot per cycle through the ram read port
// throughput: one request per cycle for append and clear, none in ST_READ or ST_SCAN
// a result stalled in the output register holds off the next request until it is taken
// reset: pointer zero and all written flags cleared, so every slot reads erased at once
module erase_on_full_entry_log
    import efl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [ADDR_W-1:0]  scan_reg, scan_next;
    logic               hit_reg, hit_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;

    logic               accept;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               slot_valid;
    logic               slot_erased;
    logic [HALF_W-1:0]  slot_low;
    logic [HALF_W-1:0]  slot_high;
    vctl_t              vctl;

    efl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({cmd.entry_high, cmd.entry_low}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    efl_valid u_valid (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (vctl),
        .rd_valid (slot_valid)
    );

    assign cmd_stall   = (state_reg != ST_IDLE) || (res_valid_reg && res_stall);
    assign accept      = cmd_valid && !cmd_stall;
    assign slot_low    = slot_valid ? ram_rdata[HALF_W-1:0] : '1;
    assign slot_high   = slot_valid ? ram_rdata[ENTRY_W-1:HALF_W] : '1;
    assign slot_erased = (slot_low == '1) && (slot_high == '1);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        scan_next      = scan_reg;
        hit_next       = hit_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg[ADDR_W-1:0];
        ram_raddr      = scan_reg;
        vctl           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.op)
                        OP_APPEND:
                        begin
                            if (ptr_reg >= FULL_PTR)
                            begin
                                vctl.clr_all = 1'b1;
                                ram_waddr    = '0;
                                ptr_next     = PTR_W'(1);
                            end
                            else
                            begin
                                ptr_next = ptr_reg + PTR_W'(1);
                            end
                            ram_we               = 1'b1;
                            vctl.set_en          = 1'b1;
                            vctl.set_addr        = ram_waddr;
                            res_next             = '0;
                            res_next.entry_count = COUNT_W'(ptr_next);
                            res_valid_next       = 1'b1;
                        end
                        OP_READ:
                        begin
                            ram_raddr  = ADDR_W'(cmd.read_index);
                            hit_next   = (32'(cmd.read_index) < 32'(ptr_reg))
                                         && (32'(cmd.read_index) < 32'(SLOTS));
                            state_next = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            vctl.clr_all         = 1'b1;
                            ptr_next             = '0;
                            res_next             = '0;
                            res_valid_next       = 1'b1;
                        end
                        OP_RECOVER:
                        begin
                            ram_raddr  = '0;
                            scan_next  = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next.data_low    = hit_reg ? slot_low : '0;
                res_next.data_high   = hit_reg ? slot_high : '0;
                res_next.read_valid  = hit_reg;
                res_next.entry_count = COUNT_W'(ptr_reg);
                res_valid_next       = 1'b1;
                state_next           = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (slot_erased || (scan_reg == LAST_SLOT))
                begin
                    if (slot_erased)
                    begin
                        ptr_next = PTR_W'(scan_reg);
                    end
                    else
                    begin
                        vctl.clr_all = 1'b1;
                        ptr_next     = '0;
                    end
                    res_next             = '0;
                    res_next.entry_count = COUNT_W'(ptr_next);
                    res_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + ADDR_W'(1);
                    ram_raddr = scan_next;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        vctl.rd_addr = ram_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            scan_reg      <= '0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            scan_reg      <= scan_next;
            hit_reg       <= hit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[hw/rtl/efl_ram.sv]
// generic simple dual-port ram with registered read
module efl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/efl_valid.sv]
// per-slot written flags with one-shot erase and registered lookup
module efl_valid
    import efl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  vctl_t ctl,
    output logic  rd_valid
);

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic             rd_valid_reg;

    always_comb
    begin
        valid_next = ctl.clr_all ? '0 : valid_reg;
        if (ctl.set_en)
        begin
            valid_next[ctl.set_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[ctl.rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;

endmodule

[hw/rtl/efl_chk.sv]
// port-level checks for the erase-on-full entry log
module efl_chk
    import efl_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic cmd_valid,
    input logic cmd_stall,
    input cmd_t cmd,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.read_valid |-> res.data_low == '0 && res.data_high == '0)
        else $error("data not zero on a result without read data");

    a_append_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd.op == OP_APPEND |=> res_valid && !res.read_valid)
        else $error("append result missing");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd.op == OP_CLEAR |=> res_valid && res.entry_count == '0)
        else $error("clear did not empty the log");

endmodule

bind erase_on_full_entry_log efl_chk u_efl_chk (.*);

[tb/erase_on_full_entry_log_tb.sv]
// self-checking testbench for the erase-on-full entry log
`timescale 1ns / 1ps

module erase_on_full_entry_log_tb;
    import efl_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [HALF_W-1:0] ALL_ONES = '1;

    logic clk = 1'b0;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    erase_on_full_entry_log dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    logic [HALF_W-1:0] log_low  [SLOTS];
    logic [HALF_W-1:0] log_high [SLOTS];
    int   log_fill;

    res_t expected_results[$];

    int tx_gap_max  = 0;
    int rx_gap_max  = 0;
    int hold_cycles = 0;
    int idle_cycles = 0;
    int mismatches  = 0;

    int n_requests       = 0;
    int n_appends        = 0;
    int n_wraps          = 0;
    int n_reads          = 0;
    int n_reads_in_range = 0;
    int n_clears         = 0;
    int n_recovers       = 0;
    int n_scan_erases    = 0;

    function automatic void log_erase();
        for (int i = 0; i < SLOTS; i++)
        begin
            log_low[i]  = ALL_ONES;
            log_high[i] = ALL_ONES;
        end
    endfunction

    function automatic res_t log_predict(input cmd_t c);
        res_t r;
        int   slot;
        bit   found;
        r = '0;
        n_requests++;
        case (c.op)
            OP_APPEND:
            begin
                n_appends++;
                if (log_fill >= SLOTS)
                begin
                    n_wraps++;
                    log_erase();
                    log_fill = 0;
                end
                log_low[log_fill]  = c.entry_low;
                log_high[log_fill] = c.entry_high;
                log_fill++;
            end
            OP_READ:
            begin
                n_reads++;
                if (int'(c.read_index) < log_fill)
                begin
                    n_reads_in_range++;
                    r.data_low   = log_low[c.read_index];
                    r.data_high  = log_high[c.read_index];
                    r.read_valid = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                n_clears++;
                log_erase();
                log_fill = 0;
            end
            default:
            begin
                n_recovers++;
                found = 1'b0;
                slot  = 0;
                for (int i = 0; i < SLOTS && !found; i++)
                begin
                    if (log_low[i] == ALL_ONES && log_high[i] == ALL_ONES)
                    begin
                        found = 1'b1;
                        slot  = i;
                    end
                end
                if (found)
                    log_fill = slot;
                else
                begin
                    n_scan_erases++;
                    log_erase();
                    log_fill = 0;
                end
            end
        endcase
        r.entry_count = COUNT_W'(log_fill);
        return r;
    endfunction

    function automatic cmd_t make_cmd(input op_t op, input logic [HALF_W-1:0] lo,
                                      input logic [HALF_W-1:0] hi,
                                      input logic [INDEX_W-1:0] idx);
        cmd_t c;
        c.op         = op;
        c.entry_low  = lo;
        c.entry_high = hi;
        c.read_index = idx;
        return c;
    endfunction

    function automatic logic [HALF_W-1:0] rand_half();
        return {$urandom, $urandom};
    endfunction

    function automatic cmd_t random_request();
        cmd_t c;
        int   pick;
        int   kind;
        c = make_cmd(OP_APPEND, rand_half(), rand_half(), INDEX_W'($urandom_range(0, 127)));
        pick = $urandom_range(0, 999);
        if (pick < 560)
        begin
            kind = $urandom_range(0, 31);
            case (kind)
                0:
                begin
                    c.entry_low  = ALL_ONES;
                    c.entry_high = ALL_ONES;
                end
                1: c.entry_low  = ALL_ONES;
                2: c.entry_high = ALL_ONES;
                3:
                begin
                    c.entry_low  = '0;
                    c.entry_high = '0;
                end
                default: ;
            endcase
        end
        else if (pick < 900)
        begin
            c.op = OP_READ;
            if (log_fill > 0 && $urandom_range(0, 3) != 0)
                c.read_index = INDEX_W'($urandom_range(0, log_fill - 1));
        end
        else if (pick < 996)
            c.op = OP_RECOVER;
        else
            c.op = OP_CLEAR;
        return c;
    endfunction

    task automatic send_request(input cmd_t c);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        expected_results.push_back(log_predict(c));
    endtask

    // receiver: random stalls, plus one long hold when asked
    initial
    begin
        int n;
        res_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = $urandom_range(0, rx_gap_max);
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (res_valid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with no request pending: %p", $realtime, res);
            end
            else
            begin
                want = expected_results.pop_front();
                if (res.data_low !== want.data_low || res.data_high !== want.data_high ||
                    res.read_valid !== want.read_valid ||
                    res.entry_count !== want.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch", $realtime);
                        $display("  data_low    exp %h got %h", want.data_low, res.data_low);
                        $display("  data_high   exp %h got %h", want.data_high, res.data_high);
                        $display("  read_valid  exp %0d got %0d",
                                 want.read_valid, res.read_valid);
                        $display("  entry_count exp %0d got %0d",
                                 want.entry_count, res.entry_count);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
            (res_valid === 1'b1 && res_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d cycles without a handshake", idle_cycles);
            $display("erase_on_full_entry_log verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        tx_gap_max = 3;
        rx_gap_max = 3;
        send_request(make_cmd(OP_READ, '0, '0, 7'd0));
        send_request(make_cmd(OP_READ, ALL_ONES, ALL_ONES, 7'd127));
        send_request(make_cmd(OP_RECOVER, '0, '0, '0));
        send_request(make_cmd(OP_APPEND, '0, '0, '0));
        send_request(make_cmd(OP_APPEND, ALL_ONES, ALL_ONES, 7'd127));
        send_request(make_cmd(OP_APPEND, ALL_ONES, '0, '0));
        send_request(make_cmd(OP_APPEND, {16{4'hA}}, {16{4'h5}}, 7'h55));
        send_request(make_cmd(OP_APPEND, {16{4'h5}}, {16{4'hA}}, 7'h2A));
        send_request(make_cmd(OP_READ, '0, '0, 7'd0));
        send_request(make_cmd(OP_READ, '0, '0, 7'd1));
        send_request(make_cmd(OP_READ, '0, '0, 7'd4));
        send_request(make_cmd(OP_READ, '0, '0, 7'd5));
        send_request(make_cmd(OP_READ, '0, '0, 7'd127));
        // all-ones entry in slot 1 pulls the pointer back
        send_request(make_cmd(OP_RECOVER, '0, '0, '0));
        send_request(make_cmd(OP_READ, '0, '0, 7'd2));
        send_request(make_cmd(OP_APPEND, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, '0));
        send_request(make_cmd(OP_APPEND, rand_half(), rand_half(), '0));
        send_request(make_cmd(OP_READ, '0, '0, 7'd2));
        send_request(make_cmd(OP_READ, '0, '0, 7'd3));
        send_request(make_cmd(OP_RECOVER, '0, '0, '0));
        send_request(make_cmd(OP_READ, '0, '0, 7'd3));
        send_request(make_cmd(OP_APPEND, ALL_ONES, '0, '0));
        send_request(make_cmd(OP_CLEAR, ALL_ONES, ALL_ONES, 7'd127));
        send_request(make_cmd(OP_READ, '0, '0, 7'd0));
        send_request(make_cmd(OP_APPEND, '0, ALL_ONES, 7'd127));
    endtask

    task automatic fill_log();
        while (log_fill < SLOTS)
            send_request(make_cmd(OP_APPEND, rand_half(), rand_half(),
                                  INDEX_W'($urandom_range(0, 127))));
    endtask

    task automatic test_full_store();
        tx_gap_max = 2;
        rx_gap_max = 2;
        send_request(make_cmd(OP_CLEAR, '0, '0, '0));
        fill_log();
        send_request(make_cmd(OP_READ, '0, '0, 7'd127));
        send_request(make_cmd(OP_READ, '0, '0, 7'd0));
        // no erased slot left, so the scan erases everything
        send_request(make_cmd(OP_RECOVER, '0, '0, '0));
        send_request(make_cmd(OP_READ, '0, '0, 7'd0));
        fill_log();
        send_request(make_cmd(OP_APPEND, rand_half(), rand_half(), '0));
        send_request(make_cmd(OP_READ, '0, '0, 7'd0));
        send_request(make_cmd(OP_READ, '0, '0, 7'd1));
    endtask

    task automatic test_backpressure();
        tx_gap_max  = 0;
        rx_gap_max  = 0;
        hold_cycles = 250;
        repeat (80) send_request(random_request());
    endtask

    task automatic test_random_traffic(input int n, input int tx_max, input int rx_max);
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        repeat (n) send_request(random_request());
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        log_erase();
        log_fill = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        test_backpressure();
        test_random_traffic(340, 0, 0);
        test_random_traffic(340, 12, 12);
        test_random_traffic(340, 0, 12);
        test_random_traffic(340, 12, 0);

        cmd_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 16) @(posedge clk);

        $display("%0d requests: %0d appends (%0d wrapped a full log), %0d reads (%0d in range)",
                 n_requests, n_appends, n_wraps, n_reads, n_reads_in_range);
        $display("%0d clears, %0d recovers (%0d erased a full log), %0d mismatches",
                 n_clears, n_recovers, n_scan_erases, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("erase_on_full_entry_log verification clean");
        else
            $display("erase_on_full_entry_log verification failed");
        $finish;
    end

endmodule
